// ----- hdl/assert_macros.svh -----
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/ffbta_pkg.sv -----
// Shared constants and codes of the boundary-tag allocator.
`default_nettype none
package ffbta_pkg;
    localparam int POOL_BYTES_DEF = 65536;
    localparam int TAG_BYTES      = 8;
    localparam int CFG_WIDTH      = 17;
    localparam logic [16:0] REG_RESET = 17'd65536;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam logic ADDR_POOL_BYTES = 1'b0;
endpackage
`default_nettype wire

// ----- hdl/ffbta_tag_ram.sv -----
// Single-port tag memory with registered read data.
`default_nettype none
module ffbta_tag_ram #(
    parameter int POOL_BYTES = ffbta_pkg::POOL_BYTES_DEF,
    parameter int AW = $clog2(POOL_BYTES / ffbta_pkg::TAG_BYTES),
    parameter int TW = $clog2(POOL_BYTES)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [TW-1:0] wdata,
    output logic      [TW-1:0] rdata
);
    localparam int DEPTH = POOL_BYTES / ffbta_pkg::TAG_BYTES;

    logic [TW-1:0] mem [DEPTH];

    // Write or read one tag per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/ffbta_engine.sv -----
// Allocate, free and pool-format sequencer: block walk, split, merge and result register.
`default_nettype none
`include "assert_macros.svh"
module ffbta_engine #(
    parameter int POOL_BYTES = ffbta_pkg::POOL_BYTES_DEF,
    parameter int OW = $clog2(POOL_BYTES) + 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          fmt_req,
    input  wire logic [OW-1:0] pool_size,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_command,
    input  wire logic [16:0]   s_request_bytes,
    input  wire logic [15:0]   s_block_offset,
    input  wire logic          s_pointer_present,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic      [1:0]    m_status,
    output logic      [15:0]   m_granted_offset
);
    localparam int AW = $clog2(POOL_BYTES / ffbta_pkg::TAG_BYTES);
    localparam int TW = $clog2(POOL_BYTES);
    localparam int CW = ((OW > 18) ? OW : 18) + 2;

    typedef enum logic [10:0] {
        S_FMT_H = 11'b000_0000_0001,
        S_FMT_F = 11'b000_0000_0010,
        S_IDLE  = 11'b000_0000_0100,
        S_A_CHK = 11'b000_0000_1000,
        S_A_TAG = 11'b000_0001_0000,
        S_F_CHK = 11'b000_0010_0000,
        S_F_TAG = 11'b000_0100_0000,
        S_F_NXT = 11'b000_1000_0000,
        S_F_PRQ = 11'b001_0000_0000,
        S_F_PRV = 11'b010_0000_0000,
        S_WR    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    logic [CW-1:0] off_reg, size_reg, hdr_reg;
    logic [15:0]   payload_reg;
    logic [1:0]    res_status_reg;
    logic [15:0]   res_grant_reg;
    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic [15:0]   m_grant_reg;

    logic [AW-1:0] wa_reg [4];
    logic [TW-1:0] wd_reg [4];
    logic [1:0]    wlast_reg, widx_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [TW-1:0] mem_wdata, mem_rdata;

    logic [CW-1:0] tag_sz, pool_c, a_end, f_end, nxt_off, off_pay, pay_c, rem;
    logic [CW-1:0] span, fmt_sz, rnd_size, m_hdr, m_size;
    logic          tag_fr, prev_ok, out_free;

    function automatic logic [AW-1:0] widx(input logic [CW-1:0] b);
        return b[AW+2:3];
    endfunction

    function automatic logic [TW-1:0] tag(input logic [CW-1:0] s, input logic f);
        return {s[TW-1:1], f};
    endfunction

    // Decode the tag just read and the sums of the walk
    always_comb begin
        tag_sz   = CW'({mem_rdata[TW-1:1], 1'b0});
        tag_fr   = mem_rdata[0];
        span     = tag_sz + CW'(16);
        pool_c   = CW'(pool_size);
        a_end    = off_reg + size_reg + CW'(16);
        f_end    = off_reg + CW'(16);
        nxt_off  = off_reg + span;
        off_pay  = off_reg + CW'(8);
        pay_c    = CW'(payload_reg);
        rem      = tag_sz - size_reg;
        fmt_sz   = pool_c - CW'(16);
        rnd_size = (CW'(s_request_bytes) + CW'(7)) & ~CW'(7);
        prev_ok  = tag_fr && (span <= hdr_reg);
        m_hdr    = prev_ok ? (hdr_reg - span) : hdr_reg;
        m_size   = prev_ok ? (size_reg + span) : size_reg;
        out_free = !m_valid_reg || m_ready;
    end

    // Drive the tag memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = widx(off_reg);
        mem_wdata = tag(fmt_sz, 1'b1);
        unique case (state_reg)
            S_FMT_H: begin
                mem_we   = 1'b1;
                mem_addr = '0;
            end
            S_FMT_F: begin
                mem_we   = 1'b1;
                mem_addr = widx(pool_c - CW'(8));
            end
            S_A_CHK: begin
                mem_re = (a_end <= pool_c);
            end
            S_F_CHK: begin
                mem_re = (f_end <= pool_c);
            end
            S_F_TAG: begin
                mem_re   = (off_pay == pay_c) && (nxt_off + CW'(16) <= pool_c);
                mem_addr = widx(nxt_off);
            end
            S_F_PRQ: begin
                mem_re   = (hdr_reg != '0);
                mem_addr = widx(hdr_reg - CW'(8));
            end
            S_WR: begin
                mem_we    = !done_reg;
                mem_addr  = wa_reg[widx_reg];
                mem_wdata = wd_reg[widx_reg];
            end
            default: begin
            end
        endcase
    end

    ffbta_tag_ram #(.POOL_BYTES(POOL_BYTES), .AW(AW), .TW(TW)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Sequence the walk
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_FMT_H: state_next = S_FMT_F;
            S_FMT_F: state_next = S_IDLE;
            S_IDLE: begin
                if (fmt_req) begin
                    state_next = S_FMT_H;
                end else if (s_valid) begin
                    if (s_command == ffbta_pkg::CMD_ALLOC) begin
                        state_next = S_A_CHK;
                    end else if (s_pointer_present) begin
                        state_next = S_F_CHK;
                    end else begin
                        state_next = S_WR;
                    end
                end
            end
            S_A_CHK: state_next = (a_end <= pool_c) ? S_A_TAG : S_WR;
            S_A_TAG: state_next = (tag_fr && tag_sz >= size_reg) ? S_WR : S_A_CHK;
            S_F_CHK: state_next = (f_end <= pool_c) ? S_F_TAG : S_WR;
            S_F_TAG: begin
                if (off_pay == pay_c) begin
                    state_next = (nxt_off + CW'(16) <= pool_c) ? S_F_NXT : S_F_PRQ;
                end else if (off_pay > pay_c) begin
                    state_next = S_WR;
                end else begin
                    state_next = S_F_CHK;
                end
            end
            S_F_NXT: state_next = S_F_PRQ;
            S_F_PRQ: state_next = (hdr_reg != '0) ? S_F_PRV : S_WR;
            S_F_PRV: state_next = S_WR;
            S_WR: begin
                if ((done_reg || widx_reg == wlast_reg) && out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_FMT_H;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_WR && state_next == S_IDLE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: walk position, pending tag writes and the result
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                off_reg        <= '0;
                size_reg       <= rnd_size;
                payload_reg    <= s_block_offset;
                widx_reg       <= '0;
                wlast_reg      <= '0;
                done_reg       <= 1'b1;
                res_status_reg <= ffbta_pkg::ST_IGNORED;
                res_grant_reg  <= '0;
            end
            S_A_CHK: begin
                if (a_end > pool_c) begin
                    res_status_reg <= ffbta_pkg::ST_NO_SPACE;
                end
            end
            S_A_TAG: begin
                if (tag_fr && tag_sz >= size_reg) begin
                    done_reg       <= 1'b0;
                    res_status_reg <= ffbta_pkg::ST_ALLOCATED;
                    res_grant_reg  <= off_pay[15:0];
                    if (rem >= CW'(16)) begin
                        wlast_reg <= 2'd3;
                        wa_reg[0] <= widx(off_reg);
                        wd_reg[0] <= tag(size_reg, 1'b0);
                        wa_reg[1] <= widx(off_pay + size_reg);
                        wd_reg[1] <= tag(size_reg, 1'b0);
                        wa_reg[2] <= widx(a_end);
                        wd_reg[2] <= tag(rem - CW'(16), 1'b1);
                        wa_reg[3] <= widx(off_pay + tag_sz);
                        wd_reg[3] <= tag(rem - CW'(16), 1'b1);
                    end else begin
                        wlast_reg <= 2'd1;
                        wa_reg[0] <= widx(off_reg);
                        wd_reg[0] <= tag(tag_sz, 1'b0);
                        wa_reg[1] <= widx(off_pay + tag_sz);
                        wd_reg[1] <= tag(tag_sz, 1'b0);
                    end
                end else begin
                    off_reg <= nxt_off;
                end
            end
            S_F_TAG: begin
                if (off_pay == pay_c) begin
                    hdr_reg        <= off_reg;
                    size_reg       <= tag_sz;
                    res_status_reg <= ffbta_pkg::ST_FREED;
                end else begin
                    off_reg <= nxt_off;
                end
            end
            S_F_NXT: begin
                if (tag_fr) begin
                    size_reg <= size_reg + span;
                end
            end
            S_F_PRQ: begin
                if (hdr_reg == '0) begin
                    done_reg  <= 1'b0;
                    wlast_reg <= 2'd1;
                    wa_reg[0] <= widx(hdr_reg);
                    wd_reg[0] <= tag(size_reg, 1'b1);
                    wa_reg[1] <= widx(hdr_reg + CW'(8) + size_reg);
                    wd_reg[1] <= tag(size_reg, 1'b1);
                end
            end
            S_F_PRV: begin
                done_reg  <= 1'b0;
                wlast_reg <= 2'd1;
                wa_reg[0] <= widx(m_hdr);
                wd_reg[0] <= tag(m_size, 1'b1);
                wa_reg[1] <= widx(m_hdr + CW'(8) + m_size);
                wd_reg[1] <= tag(m_size, 1'b1);
            end
            S_WR: begin
                if (!done_reg) begin
                    if (widx_reg == wlast_reg) begin
                        done_reg <= 1'b1;
                    end else begin
                        widx_reg <= widx_reg + 2'd1;
                    end
                end
                if (state_next == S_IDLE) begin
                    m_status_reg <= res_status_reg;
                    m_grant_reg  <= res_grant_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready          = (state_reg == S_IDLE) && !fmt_req;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_offset = m_grant_reg;

    `ASSERT_NEVER(a_rw_clash, aclk, aresetn, mem_we && mem_re, "tag read and write in one cycle")
    `ASSERT_CLK(a_leave_idle, aclk, aresetn, s_valid && s_ready |=> state_reg != S_IDLE, "request accepted but sequencer idle")
    `ASSERT_CLK(a_result_out, aclk, aresetn, state_reg == S_WR && state_next == S_IDLE |=> m_valid, "finished request produced no result")
    `ASSERT_CLK(a_fmt_pair, aclk, aresetn, state_reg == S_FMT_H |=> state_reg == S_FMT_F, "pool format wrote one tag only")
endmodule
`default_nettype wire

// ----- hdl/first_fit_boundary_tag_allocator_core.sv -----
// First-fit boundary-tag allocator: register port, pool size and sequencer.
// Use:
//   Requests enter on s_* (valid/ready): s_command 0 allocates s_request_bytes
//   rounded up to 8, 1 frees the payload at s_block_offset (ignored when
//   s_pointer_present is low). One result per request leaves on m_* with
//   m_status and m_granted_offset.
//   Sequence: allocate checks and reads the tag of each block walked, then makes
//   2 or 4 tag writes, and the result is registered with the last write; with
//   no fit it ends after the last block. Free walks the same way, then reads the
//   next header when there is one, the previous footer (skipped for the first
//   block) and makes 2 tag writes. A null free goes straight to its result, an
//   unmatched one ends with its walk.
//   Throughput: one request at a time; the next is accepted the cycle after a
//   result is registered. The walk is bound by the single-port tag memory.
//   A new request is accepted while the last result still waits on m_ready;
//   the sequencer holds when it finishes while that result is still stalled.
//   Reset formats the pool as one free block, with s_ready low. Writing
//   pool_bytes at address 0 formats it again if the sequencer is idle.
`default_nettype none
module first_fit_boundary_tag_allocator_core #(
    parameter int POOL_BYTES = ffbta_pkg::POOL_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [16:0] s_request_bytes,
    input  wire logic [15:0] s_block_offset,
    input  wire logic        s_pointer_present,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [1:0]  m_status,
    output logic      [15:0] m_granted_offset,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int OW  = $clog2(POOL_BYTES) + 1;
    localparam int CW  = ((OW > 18) ? OW : 18) + 2;
    localparam logic [CW-1:0] CAP = CW'(POOL_BYTES) & ~CW'(7);

    logic [16:0]   pool_reg;
    logic          fmt_reg;
    logic          wr_hit;
    logic [CW-1:0] rounded;
    logic [OW-1:0] eff_size;

    // Decode register writes
    assign wr_hit = psel && penable && pwrite && pready &&
                    (paddr[2] == ffbta_pkg::ADDR_POOL_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= ffbta_pkg::REG_RESET;
            fmt_reg  <= 1'b0;
        end else begin
            fmt_reg <= wr_hit;
            if (wr_hit) begin
                pool_reg <= pwdata[16:0];
            end
        end
    end

    // Round and clamp the pool size
    always_comb begin
        rounded = (CW'(pool_reg) + CW'(7)) & ~CW'(7);
        if (rounded < CW'(16)) begin
            rounded = CW'(16);
        end
        if (rounded > CAP) begin
            rounded = CAP;
        end
        eff_size = rounded[OW-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ffbta_pkg::ADDR_POOL_BYTES) ? 32'(pool_reg) : '0;

    ffbta_engine #(.POOL_BYTES(POOL_BYTES), .OW(OW)) u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .fmt_req           (fmt_reg),
        .pool_size         (eff_size),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_request_bytes   (s_request_bytes),
        .s_block_offset    (s_block_offset),
        .s_pointer_present (s_pointer_present),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_offset  (m_granted_offset)
    );
endmodule
`default_nettype wire
